// ===== src/bdq_pkg.sv =====
package bdq_pkg;

  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  // one result slot handed from the controller to the response pipeline
  typedef struct packed {
    logic    valid;
    logic    from_mem;
    status_t status;
    logic    last;
  } stage_t;

endpackage

// ===== src/bdq_req_if.sv =====
interface bdq_req_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== src/bdq_rsp_if.sv =====
interface bdq_rsp_if import bdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;
  logic                     last;

  modport source (output valid, output result_value, output status, output last,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last,
                  output ready);
endinterface

// ===== src/bdq_mem.sv =====
module bdq_mem import bdq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low; the response stage relies on that
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

// ===== src/bdq_ctrl.sv =====
module bdq_ctrl import bdq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int PW       = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [OP_W-1:0]   req_operation,
  input  logic [DATA_W-1:0] req_value,
  output logic              req_ready,
  input  logic              load_ok,
  output stage_t            stage,
  output logic              we,
  output logic [PW-1:0]     waddr,
  output logic [DATA_W-1:0] wdata,
  output logic              re,
  output logic [PW-1:0]     raddr
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = PW + 1;

  state_t        state, state_next;
  logic [PW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [PW-1:0] rp, rp_next;
  logic [CW-1:0] rem, rem_next;

  logic          accept;
  logic          full, empty;
  logic [PW-1:0] front_dec, front_inc, rp_inc;
  logic [SW-1:0] sum_ins, sum_pop;
  logic [PW-1:0] back_ins, back_pop;

  assign req_ready = (state == S_IDLE) && load_ok;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);

  assign front_dec = (front == '0) ? PW'(CAPACITY - 1) : front - PW'(1);
  assign front_inc = (front == PW'(CAPACITY - 1)) ? '0 : front + PW'(1);
  assign rp_inc    = (rp == PW'(CAPACITY - 1)) ? '0 : rp + PW'(1);

  // positions stay below twice the capacity, so one subtract wraps them
  assign sum_ins  = {1'b0, front} + SW'(count);
  assign sum_pop  = {1'b0, front} + SW'(count) - SW'(1);
  assign back_ins = (sum_ins >= SW'(CAPACITY)) ? PW'(sum_ins - SW'(CAPACITY)) : PW'(sum_ins);
  assign back_pop = (sum_pop >= SW'(CAPACITY)) ? PW'(sum_pop - SW'(CAPACITY)) : PW'(sum_pop);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (req_operation == OP_LIST) && (count > CW'(1))) begin
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        if (load_ok && (rem == CW'(1))) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    stage      = '{valid: 1'b0, from_mem: 1'b0, status: ST_OK, last: 1'b0};
    we         = 1'b0;
    waddr      = back_ins;
    wdata      = req_value;
    re         = 1'b0;
    raddr      = front;
    front_next = front;
    count_next = count;
    rp_next    = rp;
    rem_next   = rem;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              stage.valid = 1'b1;
              stage.last  = 1'b1;
              if (full) begin
                stage.status = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
                if (req_operation == OP_PUSH_FRONT) begin
                  waddr      = front_dec;
                  front_next = front_dec;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              stage.valid = 1'b1;
              stage.last  = 1'b1;
              if (empty) begin
                stage.status = ST_EMPTY;
              end else begin
                re             = 1'b1;
                stage.from_mem = 1'b1;
                count_next     = count - CW'(1);
                if (req_operation == OP_POP_FRONT) begin
                  front_next = front_inc;
                end else begin
                  raddr = back_pop;
                end
              end
            end
            OP_LIST: begin
              stage.valid = 1'b1;
              if (empty) begin
                stage.status = ST_EMPTY;
                stage.last   = 1'b1;
              end else begin
                re             = 1'b1;
                stage.from_mem = 1'b1;
                stage.last     = (count == CW'(1));
                rp_next        = front_inc;
                rem_next       = count - CW'(1);
              end
            end
            default: ;  // unused codes are dropped
          endcase
        end
      end
      S_LIST: begin
        if (load_ok) begin
          re             = 1'b1;
          raddr          = rp;
          stage.valid    = 1'b1;
          stage.from_mem = 1'b1;
          stage.last     = (rem == CW'(1));
          rp_next        = rp_inc;
          rem_next       = rem - CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      rp    <= '0;
      rem   <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      rp    <= rp_next;
      rem   <= rem_next;
    end
  end

endmodule

// ===== src/bdq_resp.sv =====
module bdq_resp import bdq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  stage_t            stage,
  input  logic [DATA_W-1:0] rd_data,
  output logic              load_ok,
  bdq_rsp_if.source         rsp
);

  logic          s1_valid;
  logic          s1_from_mem;
  status_t       s1_status;
  logic          s1_last;
  logic          s1_move;

  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  status_t           out_status;
  logic              out_last;

  // memory data is aligned with s1; out register decouples the receiver
  assign s1_move = s1_valid && (!out_valid || rsp.ready);
  assign load_ok = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_ok) begin
        s1_valid <= stage.valid;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && stage.valid) begin
      s1_from_mem <= stage.from_mem;
      s1_status   <= stage.status;
      s1_last     <= stage.last;
    end
    if (s1_move) begin
      out_value  <= s1_from_mem ? rd_data : '0;
      out_status <= s1_status;
      out_last   <= s1_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.last         = out_last;

endmodule

// ===== src/bounded_deque_with_listing_unit.sv =====
// Bounded double-ended queue of signed 32-bit words with a listing request.
// Channel req carries operation and value: push front, push back, pop front,
// pop back, or list all entries front to back. Codes 5 to 7 are taken and
// dropped without a response. Channel rsp returns result_value, status and
// last; last marks the final response of each request.
// A push answers with an ack (status ok) or full; a pop answers with the
// removed word or empty; a list answers one response per entry, or a single
// empty response.
// A response passes the s1 stage and the output register before rsp.
// Push and pop are taken back to back while rsp does not stall. A listing
// holds req.ready low while it reads the remaining entries from the entry
// RAM one word per cycle when the response path has room (one read port).
// Reset: synchronous; the queue comes up empty. RAM contents are not cleared.
// Stall: when rsp.ready is low the output register and one stage behind it
// fill, then req.ready drops; nothing is lost or repeated.
module bounded_deque_with_listing_unit import bdq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);

  localparam int PW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  stage_t            stage;
  logic              load_ok;
  logic              we, re;
  logic [PW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rd_data;

  bdq_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_operation (req.operation),
    .req_value     (req.value),
    .req_ready     (req.ready),
    .load_ok       (load_ok),
    .stage         (stage),
    .we            (we),
    .waddr         (waddr),
    .wdata         (wdata),
    .re            (re),
    .raddr         (raddr)
  );

  bdq_mem #(
    .DEPTH (CAPACITY),
    .AW    (PW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  bdq_resp u_resp (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .rd_data (rd_data),
    .load_ok (load_ok),
    .rsp     (rsp)
  );

`ifndef SYNTHESIS
  a_issue_has_room: assert property (@(posedge clk) disable iff (rst)
    stage.valid |-> load_ok)
    else $error("response issued while the pipeline is blocked");

  a_read_has_slot: assert property (@(posedge clk) disable iff (rst)
    re |-> (stage.valid && stage.from_mem))
    else $error("RAM read without a matching response slot");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    we |-> !re)
    else $error("RAM write and read in the same cycle");
`endif

endmodule

// ===== bench/tb_bounded_deque_with_listing_unit.sv =====
`timescale 1ns / 1ps

module tb_bounded_deque_with_listing_unit;
  import bdq_pkg::*;

  localparam int CAP             = 64;
  localparam int REQUEST_TARGET  = 270;
  localparam int IDLE_LIMIT      = 4000;
  localparam int TAIL_CYCLES     = 8;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
    int                       gap;
  } deque_request_t;

  typedef struct {
    logic signed [DATA_W-1:0] result_value;
    status_t                  status;
    logic                     last;
  } deque_result_t;

  typedef enum {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_t;

  logic clk;
  logic rst;

  bdq_req_if req_ch ();
  bdq_rsp_if rsp_ch ();

  bounded_deque_with_listing_unit #(.CAPACITY(CAP)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  deque_request_t request_plan[$];
  deque_result_t  pending_results[$];

  // predicted deque contents
  logic signed [DATA_W-1:0] deque_store [CAP];
  int deque_head;
  int deque_fill;

  int failures;
  int shadow_fill;
  int quiet_run;
  int calm_left;
  int stall_left;
  int idle_cycles;
  bit request_taken;
  deque_request_t next_req;
  deque_result_t  want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    if (quiet_run > 0) begin
      quiet_run--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      quiet_run = $urandom_range(15, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // appends one request and tracks the occupancy the stimulus will produce
  task automatic plan_request(input logic [OP_W-1:0] operation,
                              input logic signed [DATA_W-1:0] value);
    deque_request_t r;
    r.operation = operation;
    r.value     = value;
    r.gap       = pick_gap();
    request_plan.push_back(r);
    case (operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (shadow_fill < CAP) shadow_fill++;
      OP_POP_FRONT, OP_POP_BACK:   if (shadow_fill > 0) shadow_fill--;
      default: ;
    endcase
  endtask

  task automatic add_result(input logic signed [DATA_W-1:0] result_value,
                            input status_t status, input logic last);
    deque_result_t e;
    e.result_value = result_value;
    e.status       = status;
    e.last         = last;
    pending_results.push_back(e);
  endtask

  task automatic deque_apply(input logic [OP_W-1:0] operation,
                             input logic signed [DATA_W-1:0] value);
    int pos;
    case (operation)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (deque_fill >= CAP) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          if (operation == OP_PUSH_FRONT) begin
            deque_head = (deque_head + CAP - 1) % CAP;
            pos = deque_head;
          end else begin
            pos = (deque_head + deque_fill) % CAP;
          end
          deque_store[pos] = value;
          deque_fill++;
          add_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (deque_fill == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (operation == OP_POP_FRONT) begin
            pos = deque_head;
            deque_head = (deque_head + 1) % CAP;
          end else begin
            pos = (deque_head + deque_fill - 1) % CAP;
          end
          deque_fill--;
          add_result(deque_store[pos], ST_OK, 1'b1);
        end
      end
      OP_LIST: begin
        if (deque_fill == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < deque_fill; i++)
            add_result(deque_store[(deque_head + i) % CAP], ST_OK, i == deque_fill - 1);
        end
      end
      default: ; // unused codes are dropped silently
    endcase
  endtask

  // stimulus plan, reset and end of run
  initial begin
    mix_t mix;
    int   full_seen;
    int   empty_seen;
    int   mix_items;
    int   roll;
    logic [OP_W-1:0] op;

    rst              = 1'b1;
    shadow_fill      = 0;
    quiet_run        = 0;

    // directed: empty cases, unused codes, extreme values, both ends
    plan_request(OP_POP_FRONT, 32'sh1234_5678);
    plan_request(OP_POP_BACK, -32'sd1);
    plan_request(OP_LIST, -32'sd1);
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++)
      plan_request(c[OP_W-1:0], -32'sd1);
    plan_request(OP_PUSH_FRONT, 32'sh8000_0000);
    plan_request(OP_PUSH_BACK, 32'sh7fff_ffff);
    plan_request(OP_PUSH_FRONT, 32'sh0000_0000);
    plan_request(OP_PUSH_BACK, -32'sd1);
    plan_request(OP_PUSH_FRONT, 32'shaaaa_aaaa);
    plan_request(OP_PUSH_BACK, 32'sh5555_5555);
    plan_request(OP_LIST, '0);
    plan_request(OP_POP_FRONT, '0);
    plan_request(OP_POP_BACK, '0);
    plan_request(OP_LIST, '0);
    plan_request(OP_POP_FRONT, '0);
    plan_request(OP_POP_BACK, '0);
    plan_request(OP_POP_FRONT, '0);
    plan_request(OP_POP_BACK, '0);
    plan_request(OP_POP_FRONT, '0);

    // random: fill to full, drain to empty, then mixed traffic, repeated
    mix         = MIX_FILL;
    full_seen   = 0;
    empty_seen  = 0;
    mix_items   = 0;
    while (request_plan.size() < REQUEST_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll >= 96) begin
        op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else if (roll >= 90) begin
        op = OP_LIST;
      end else begin
        case (mix)
          MIX_FILL:
            if (roll < 84) op = roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else           op = roll[0] ? OP_POP_FRONT : OP_POP_BACK;
          MIX_DRAIN:
            if (roll < 8) op = roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else          op = roll[0] ? OP_POP_FRONT : OP_POP_BACK;
          default:
            if (roll < 45) op = roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else           op = roll[0] ? OP_POP_FRONT : OP_POP_BACK;
        endcase
      end
      plan_request(op, pick_value());
      case (mix)
        MIX_FILL: if (shadow_fill == CAP) begin
          full_seen++;
          if (full_seen >= 3) begin
            mix = MIX_DRAIN;
            full_seen = 0;
          end
        end
        MIX_DRAIN: if (shadow_fill == 0) begin
          empty_seen++;
          if (empty_seen >= 3) begin
            mix = MIX_BALANCED;
            empty_seen = 0;
            mix_items = 0;
          end
        end
        default: begin
          mix_items++;
          if (mix_items >= 40) mix = MIX_FILL;
        end
      endcase
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (request_plan.size() != 0 || req_ch.valid);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
    end
    if (failures == 0 && pending_results.size() == 0) begin
      $display("PASS bounded_deque_with_listing_unit");
    end else begin
      $display("FAIL bounded_deque_with_listing_unit");
    end
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= '0;
      req_ch.value     <= '0;
    end else if (!req_ch.valid || request_taken) begin
      if (request_plan.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (request_plan[0].gap != 0) begin
        req_ch.valid <= 1'b0;
        request_plan[0].gap = request_plan[0].gap - 1;
      end else begin
        next_req = request_plan.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.operation <= next_req.operation;
        req_ch.value     <= next_req.value;
      end
    end
  end

  // response backpressure: calm stretches, short stalls, occasional long ones
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left--;
      rsp_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:2]: begin
          calm_left = $urandom_range(20, 60);
          rsp_ch.ready <= 1'b1;
        end
        [3:17]: begin
          stall_left = $urandom_range(0, 2);
          rsp_ch.ready <= 1'b0;
        end
        [18:20]: begin
          stall_left = $urandom_range(9, 39);
          rsp_ch.ready <= 1'b0;
        end
        default: rsp_ch.ready <= 1'b1;
      endcase
    end
  end

  // monitor: predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    request_taken = !rst && req_ch.valid && req_ch.ready;
    if (request_taken)
      deque_apply(req_ch.operation, req_ch.value);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected response: result_value %0d status %0d last %0b",
               rsp_ch.result_value, rsp_ch.status, rsp_ch.last);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 want.result_value, rsp_ch.result_value);
          failures++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          failures++;
        end
        if (rsp_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL bounded_deque_with_listing_unit");
        $finish;
      end
    end
  end

endmodule

// ===== bounded_deque_with_listing_unit.f =====
src/bdq_pkg.sv
src/bdq_req_if.sv
src/bdq_rsp_if.sv
src/bdq_mem.sv
src/bdq_ctrl.sv
src/bdq_resp.sv
src/bounded_deque_with_listing_unit.sv
bench/tb_bounded_deque_with_listing_unit.sv
